/* rtl/core/dras_pkg.sv */
// Shared types and codes for the deferred-release slot allocator.
`default_nettype none

package dras_pkg;

    localparam int unsigned IDX_W  = 15;
    localparam int unsigned HEAP_W = 32;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RECLAIM = 2'd2;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_RELEASED  = 3'd2;
    localparam logic [2:0] ST_RESERVED  = 3'd3;
    localparam logic [2:0] ST_NOT_OCC   = 3'd4;
    localparam logic [2:0] ST_PEND_FULL = 3'd5;
    localparam logic [2:0] ST_RECLAIMED = 3'd6;
    localparam logic [2:0] ST_NONE_PEND = 3'd7;

    localparam logic [1:0] DW_NONE     = 2'd0;
    localparam logic [1:0] DW_TEXTURE  = 2'd1;
    localparam logic [1:0] DW_FALLBACK = 2'd2;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  result_index;
        logic [HEAP_W-1:0] heap_slot;
        logic [1:0]        descriptor_write;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/dras_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module dras_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/dras_seq.sv */
// Sequencer: counters, read-modify-write control of the three memories, result forming.
`default_nettype none

module dras_seq #(
    parameter int unsigned SLOTS         = 32768,
    parameter int unsigned RESERVED_LAST = 2,
    parameter int unsigned PENDING_DEPTH = 64,
    parameter int unsigned PARITIES      = 2,
    localparam int unsigned IW  = $clog2(SLOTS),
    localparam int unsigned PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
    localparam int unsigned PBW = $clog2(PARITIES),
    localparam int unsigned PDEPTH = 2 ** (PBW + PAW)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Item side
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_operation,
    input  wire logic [dras_pkg::IDX_W-1:0] i_slot_index,
    input  wire logic                      i_frame_parity,
    input  wire logic [dras_pkg::HEAP_W-1:0] i_heap_base,
    // Result side
    input  wire logic                      i_res_free,
    output logic                           o_res_valid,
    output dras_pkg::t_result              o_res,
    // Occupied-bit memory
    output logic                           o_occ_we,
    output logic [IW-1:0]                  o_occ_waddr,
    output logic                           o_occ_wdata,
    output logic                           o_occ_re,
    output logic [IW-1:0]                  o_occ_raddr,
    input  wire logic                      i_occ_rdata,
    // Free stack memory
    output logic                           o_stk_we,
    output logic [IW-1:0]                  o_stk_waddr,
    output logic [IW-1:0]                  o_stk_wdata,
    output logic                           o_stk_re,
    output logic [IW-1:0]                  o_stk_raddr,
    input  wire logic [IW-1:0]             i_stk_rdata,
    // Pending list memory
    output logic                           o_pnd_we,
    output logic [$clog2(PDEPTH)-1:0]      o_pnd_waddr,
    output logic [IW-1:0]                  o_pnd_wdata,
    output logic                           o_pnd_re,
    output logic [$clog2(PDEPTH)-1:0]      o_pnd_raddr,
    input  wire logic [IW-1:0]             i_pnd_rdata
);

    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
    localparam int unsigned XW  = (CW > dras_pkg::IDX_W) ? CW : dras_pkg::IDX_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                        r_state, n_state;
    logic [1:0]                  r_op;
    logic [dras_pkg::IDX_W-1:0]  r_sidx;
    logic                        r_par;
    logic [CW-1:0]               r_fc, n_fc;
    logic [CW-1:0]               r_nf, n_nf;
    logic [PCW-1:0]              r_pcnt [PARITIES];
    logic [PCW-1:0]              n_pcnt;
    logic                        n_pcnt_we;
    logic [PCW-1:0]              r_drain, n_drain;

    logic                        w_accept;
    logic [CW-1:0]               w_fc_m1;
    logic [XW-1:0]               w_in_sidx_x;
    logic [XW-1:0]               w_sidx_x;
    logic [PBW-1:0]              w_pidx;
    logic [PCW-1:0]              w_n;
    logic [PCW-1:0]              w_drain_p1;
    logic [IW-1:0]               w_idx;
    logic                        w_last;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_fc_m1     = r_fc - CW'(1);
    assign w_in_sidx_x = XW'(i_slot_index);
    assign w_sidx_x    = XW'(r_sidx);
    assign w_pidx      = PBW'(r_par);
    assign w_n         = r_pcnt[w_pidx];
    assign w_drain_p1  = r_drain + PCW'(1);
    assign w_last      = (r_drain == (w_n - PCW'(1)));

    // Reads are issued at the accepting edge; the data is used in the execute cycle.
    assign o_stk_re    = w_accept && (i_operation == dras_pkg::OP_ALLOC);
    assign o_stk_raddr = w_fc_m1[IW-1:0];
    assign o_occ_re    = w_accept && (i_operation == dras_pkg::OP_RELEASE);
    assign o_occ_raddr = w_in_sidx_x[IW-1:0];

    always_comb begin
        n_state     = r_state;
        n_fc        = r_fc;
        n_nf        = r_nf;
        n_pcnt      = w_n;
        n_pcnt_we   = 1'b0;
        n_drain     = r_drain;
        w_idx       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;
        o_occ_we    = 1'b0;
        o_occ_waddr = w_sidx_x[IW-1:0];
        o_occ_wdata = 1'b0;
        o_stk_we    = 1'b0;
        o_stk_waddr = r_fc[IW-1:0];
        o_stk_wdata = i_pnd_rdata;
        o_pnd_we    = 1'b0;
        o_pnd_waddr = {w_pidx, w_n[PAW-1:0]};
        o_pnd_wdata = w_sidx_x[IW-1:0];
        o_pnd_re    = w_accept && (i_operation == dras_pkg::OP_RECLAIM);
        o_pnd_raddr = {PBW'(i_frame_parity), PAW'(0)};

        if (r_state == S_EXEC) begin
            case (r_op)
                dras_pkg::OP_ALLOC: begin
                    if (i_res_free) begin
                        o_res_valid = 1'b1;
                        n_state     = S_IDLE;
                        if ((r_fc == '0) && (r_nf >= CW'(SLOTS))) begin
                            o_res.status = dras_pkg::ST_EXHAUSTED;
                        end else begin
                            if (r_fc != '0) begin
                                w_idx = i_stk_rdata;
                                n_fc  = w_fc_m1;
                            end else begin
                                w_idx = r_nf[IW-1:0];
                                n_nf  = r_nf + CW'(1);
                            end
                            o_occ_we               = 1'b1;
                            o_occ_waddr            = w_idx;
                            o_occ_wdata            = 1'b1;
                            o_res.status           = dras_pkg::ST_GRANTED;
                            o_res.result_index     = dras_pkg::IDX_W'(w_idx);
                            o_res.heap_slot        = i_heap_base + dras_pkg::HEAP_W'(w_idx);
                            o_res.descriptor_write = dras_pkg::DW_TEXTURE;
                        end
                    end
                end
                dras_pkg::OP_RELEASE: begin
                    if (i_res_free) begin
                        o_res_valid = 1'b1;
                        n_state     = S_IDLE;
                        if ((w_sidx_x <= XW'(RESERVED_LAST)) || (w_sidx_x >= XW'(r_nf))
                                || (w_sidx_x >= XW'(SLOTS))) begin
                            o_res.status = dras_pkg::ST_RESERVED;
                        end else if (!i_occ_rdata) begin
                            o_res.status = dras_pkg::ST_NOT_OCC;
                        end else if (w_n >= PCW'(PENDING_DEPTH)) begin
                            o_res.status = dras_pkg::ST_PEND_FULL;
                        end else begin
                            o_occ_we           = 1'b1;
                            o_pnd_we           = 1'b1;
                            n_pcnt             = w_n + PCW'(1);
                            n_pcnt_we          = 1'b1;
                            o_res.status       = dras_pkg::ST_RELEASED;
                            o_res.result_index = r_sidx;
                        end
                    end
                end
                dras_pkg::OP_RECLAIM: begin
                    if (i_res_free) begin
                        o_res_valid = 1'b1;
                        if (w_n == '0) begin
                            o_res.status = dras_pkg::ST_NONE_PEND;
                            n_state      = S_IDLE;
                        end else begin
                            o_res.status           = dras_pkg::ST_RECLAIMED;
                            o_res.result_index     = dras_pkg::IDX_W'(i_pnd_rdata);
                            o_res.heap_slot        = i_heap_base
                                                     + dras_pkg::HEAP_W'(i_pnd_rdata);
                            o_res.descriptor_write = dras_pkg::DW_FALLBACK;
                            o_res.last             = w_last;
                            if (r_fc < CW'(SLOTS)) begin
                                o_stk_we = 1'b1;
                                n_fc     = r_fc + CW'(1);
                            end
                            if (w_last) begin
                                n_pcnt    = '0;
                                n_pcnt_we = 1'b1;
                                n_drain   = '0;
                                n_state   = S_IDLE;
                            end else begin
                                // Fetch the next queued entry while this one leaves.
                                n_drain     = w_drain_p1;
                                o_pnd_re    = 1'b1;
                                o_pnd_raddr = {w_pidx, w_drain_p1[PAW-1:0]};
                            end
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end else if (w_accept) begin
            n_state = S_EXEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fc    <= '0;
            r_nf    <= '0;
            r_drain <= '0;
            for (int p = 0; p < PARITIES; p++) begin
                r_pcnt[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_fc    <= n_fc;
            r_nf    <= n_nf;
            r_drain <= n_drain;
            if (n_pcnt_we) begin
                r_pcnt[w_pidx] <= n_pcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_sidx <= i_slot_index;
            r_par  <= i_frame_parity;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted beat did not enter execute");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> (r_state == S_IDLE))
        else $error("final result did not return sequencer to idle");

    a_free_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= r_nf)
        else $error("free stack holds more slots than were ever handed out");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= CW'(SLOTS))
        else $error("bump counter passed the slot count");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt[0] <= PCW'(PENDING_DEPTH)) && (r_pcnt[PARITIES-1] <= PCW'(PENDING_DEPTH)))
        else $error("pending count passed the list depth");

endmodule

`default_nettype wire

/* rtl/core/deferred_release_slot_allocator.sv */
// Top level of the deferred-release slot allocator: config register, memories, result register.
//
// Usage: one command beat enters on the input channel (i_in_valid / o_in_stall) and carries
// an operation (allocate, release, reclaim), a slot index and a frame parity. Result beats
// leave on the output channel (o_out_valid / i_out_stall). Allocate and release give one
// result each; reclaim gives one result per queued slot (last marks the final one), or one
// "nothing pending" result. heap_base must be written by the user through i_cfg_we / i_cfg_wdata
// only while idle; the block does not enforce it. A result passes from the execute state into
// the output register, and waits in execute while that register holds a stalled beat.
// An allocate or release is accepted with its memory read, then does the read-modify-write;
// a reclaim reads the pending list once per result, fetching the next entry as one leaves.
// The registered read data of the state memories sets this order.
// Stall: the output register holds its beat while i_out_stall is high; the sequencer then
// waits in its execute cycle, and o_in_stall stays high until the command is finished.
// Reset (synchronous, i_rst_n low) clears the counters, pending counts, heap_base and the
// output valid. No memory clearing pass is needed: occupied bits are only used below the
// high-water mark, and every slot there was written when it was first granted.
`default_nettype none

module deferred_release_slot_allocator #(
    parameter int unsigned SLOTS         = 32768,
    parameter int unsigned RESERVED_LAST = 2,
    parameter int unsigned PENDING_DEPTH = 64,
    parameter int unsigned PARITIES      = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [dras_pkg::HEAP_W-1:0]  i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [dras_pkg::IDX_W-1:0]   i_slot_index,
    input  wire logic                         i_frame_parity,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [2:0]                        o_status,
    output logic [dras_pkg::IDX_W-1:0]        o_result_index,
    output logic [dras_pkg::HEAP_W-1:0]       o_heap_slot,
    output logic [1:0]                        o_descriptor_write,
    output logic                              o_last
);

    localparam int unsigned IW     = $clog2(SLOTS);
    localparam int unsigned PAW    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned PBW    = $clog2(PARITIES);
    localparam int unsigned PDEPTH = 2 ** (PBW + PAW);
    localparam int unsigned PAD    = $clog2(PDEPTH);

    logic [dras_pkg::HEAP_W-1:0] r_heap_base;
    logic                        r_out_valid;
    dras_pkg::t_result           r_out;

    logic                        w_res_free;
    logic                        w_res_valid;
    dras_pkg::t_result           w_res;

    logic           w_occ_we, w_occ_wdata, w_occ_re, w_occ_rdata;
    logic [IW-1:0]  w_occ_waddr, w_occ_raddr;
    logic           w_stk_we, w_stk_re;
    logic [IW-1:0]  w_stk_waddr, w_stk_wdata, w_stk_raddr, w_stk_rdata;
    logic           w_pnd_we, w_pnd_re;
    logic [PAD-1:0] w_pnd_waddr, w_pnd_raddr;
    logic [IW-1:0]  w_pnd_wdata, w_pnd_rdata;

    // The output register can take a new result when empty or when its beat leaves now.
    assign w_res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_base <= i_cfg_wdata;
            end
            if (w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_result_index     = r_out.result_index;
    assign o_heap_slot        = r_out.heap_slot;
    assign o_descriptor_write = r_out.descriptor_write;
    assign o_last             = r_out.last;

    dras_seq #(
        .SLOTS         (SLOTS),
        .RESERVED_LAST (RESERVED_LAST),
        .PENDING_DEPTH (PENDING_DEPTH),
        .PARITIES      (PARITIES)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_slot_index   (i_slot_index),
        .i_frame_parity (i_frame_parity),
        .i_heap_base    (r_heap_base),
        .i_res_free     (w_res_free),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .o_occ_we       (w_occ_we),
        .o_occ_waddr    (w_occ_waddr),
        .o_occ_wdata    (w_occ_wdata),
        .o_occ_re       (w_occ_re),
        .o_occ_raddr    (w_occ_raddr),
        .i_occ_rdata    (w_occ_rdata),
        .o_stk_we       (w_stk_we),
        .o_stk_waddr    (w_stk_waddr),
        .o_stk_wdata    (w_stk_wdata),
        .o_stk_re       (w_stk_re),
        .o_stk_raddr    (w_stk_raddr),
        .i_stk_rdata    (w_stk_rdata),
        .o_pnd_we       (w_pnd_we),
        .o_pnd_waddr    (w_pnd_waddr),
        .o_pnd_wdata    (w_pnd_wdata),
        .o_pnd_re       (w_pnd_re),
        .o_pnd_raddr    (w_pnd_raddr),
        .i_pnd_rdata    (w_pnd_rdata)
    );

    // Occupied bit per slot.
    dras_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (w_occ_we),
        .i_waddr (w_occ_waddr),
        .i_wdata (w_occ_wdata),
        .i_re    (w_occ_re),
        .i_raddr (w_occ_raddr),
        .o_rdata (w_occ_rdata)
    );

    // LIFO free stack of reclaimed slots.
    dras_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // Pending lists, one region per frame parity.
    dras_ram #(.WIDTH(IW), .DEPTH(PDEPTH)) u_pnd_ram (
        .i_clk   (i_clk),
        .i_we    (w_pnd_we),
        .i_waddr (w_pnd_waddr),
        .i_wdata (w_pnd_wdata),
        .i_re    (w_pnd_re),
        .i_raddr (w_pnd_raddr),
        .o_rdata (w_pnd_rdata)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_out)))
        else $error("stalled result beat changed");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_res_free)
        else $error("result loaded over a beat still waiting");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res.last) |=> o_in_stall)
        else $error("command accepted before reclaim finished");

endmodule

`default_nettype wire
